// ===== hdl/amcs_pkg.sv =====
`default_nettype none

package amcs_pkg;

  localparam int TIME_BITS_DEF = 16;
  localparam int FRAME_LEN     = 10;
  localparam int IDX_BITS      = $clog2(FRAME_LEN);
  localparam int CFG_BITS      = 10;

  // Frame framing bytes
  localparam logic [7:0] FRAME_HEAD    = 8'h7E;
  localparam logic [7:0] VERSION_BYTE  = 8'hFF;
  localparam logic [7:0] LENGTH_BYTE   = 8'h06;
  localparam logic [7:0] FEEDBACK_BYTE = 8'h00;
  localparam logic [7:0] PARAM1_BYTE   = 8'h00;
  localparam logic [7:0] FRAME_TAIL    = 8'hEF;

  // Command codes
  localparam logic [7:0] CMD_SELECT_SOURCE = 8'h3F;
  localparam logic [7:0] CMD_SET_VOLUME    = 8'h06;
  localparam logic [7:0] CMD_PAUSE         = 8'h0E;
  localparam logic [7:0] CMD_RESUME        = 8'h0D;
  localparam logic [7:0] CMD_PREVIOUS      = 8'h02;
  localparam logic [7:0] CMD_NEXT          = 8'h01;
  localparam logic [7:0] CMD_PLAY_TRACK    = 8'h03;

  localparam logic [7:0] SOURCE_SD     = 8'h02;
  localparam logic [7:0] FIRST_TRACK   = 8'h01;
  localparam logic [7:0] NO_PARAM      = 8'h00;

  // Register reset values
  localparam logic [4:0]          VOLUME_RST      = 5'd20;
  localparam logic [CFG_BITS-1:0] DEBOUNCE_RST    = 10'd50;
  localparam logic [CFG_BITS-1:0] INIT_DELAY_RST  = 10'd50;
  localparam logic [CFG_BITS-1:0] VOL_DELAY_RST   = 10'd100;

  typedef enum logic [1:0] {
    REG_VOLUME     = 2'd0,
    REG_DEBOUNCE   = 2'd1,
    REG_INIT_DELAY = 2'd2,
    REG_VOL_DELAY  = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_START       = 2'd0,
    MODE_WAIT_SOURCE = 2'd1,
    MODE_WAIT_VOLUME = 2'd2,
    MODE_IDLE        = 2'd3
  } mode_t;

  typedef struct packed {
    logic [4:0]          volume_level;
    logic [CFG_BITS-1:0] debounce_ms;
    logic [CFG_BITS-1:0] init_delay_ms;
    logic [CFG_BITS-1:0] volume_delay_ms;
  } cfg_t;

  // One command waiting to be framed
  typedef struct packed {
    logic [7:0]  cmd;
    logic [7:0]  p2;
    logic [15:0] chk;
    logic        playing;
    logic        paused;
  } cmd_desc_t;

  // Negated 16-bit sum of version, length, cmd, feedback, p1 and p2
  function automatic logic [15:0] frame_checksum(logic [7:0] cmd, logic [7:0] p2);
    logic [15:0] sum;
    sum = 16'(VERSION_BYTE) + 16'(LENGTH_BYTE) + 16'(cmd) + 16'(FEEDBACK_BYTE)
        + 16'(PARAM1_BYTE) + 16'(p2);
    return 16'(16'd0 - sum);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/amcs_if.sv =====
`default_nettype none

interface amcs_tick_if;
  logic valid;
  logic ready;
  logic pause_press;
  logic prev_press;
  logic next_press;
  logic play_request;

  modport source (output valid, pause_press, prev_press, next_press, play_request,
                  input ready);
  modport sink   (input valid, pause_press, prev_press, next_press, play_request,
                  output ready);
endinterface

interface amcs_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;
  logic       playing;
  logic       paused;

  modport source (output valid, frame_byte, last_byte, playing, paused,
                  input ready);
  modport sink   (input valid, frame_byte, last_byte, playing, paused,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/amcs_core.sv =====
`default_nettype none

module amcs_core
  import amcs_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cfg_t      cfg,
  input  wire logic      tick_valid,
  input  wire logic      pause_press,
  input  wire logic      prev_press,
  input  wire logic      next_press,
  input  wire logic      play_request,
  output logic           desc_valid,
  output cmd_desc_t      desc
);

  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  mode_t                mode, mode_next;
  logic [TIME_BITS-1:0] wait_count, wait_count_next, wait_inc;
  logic [TIME_BITS-1:0] pause_since, previous_since, next_since;
  logic [TIME_BITS-1:0] pause_inc, previous_inc, next_inc;
  logic [TIME_BITS-1:0] debounce;
  logic                 play_flag, pause_flag, play_flag_next, pause_flag_next;
  logic                 acc_pause, acc_prev, acc_next;
  logic                 emit;
  logic [7:0]           cmd, p2;

  assign debounce     = TIME_BITS'(cfg.debounce_ms);
  assign pause_inc    = (pause_since == TIME_MAX) ? TIME_MAX : pause_since + 1'b1;
  assign previous_inc = (previous_since == TIME_MAX) ? TIME_MAX : previous_since + 1'b1;
  assign next_inc     = (next_since == TIME_MAX) ? TIME_MAX : next_since + 1'b1;
  assign wait_inc     = (wait_count == TIME_MAX) ? TIME_MAX : wait_count + 1'b1;

  assign acc_pause = pause_press && (pause_inc > debounce);
  assign acc_prev  = prev_press && (previous_inc > debounce);
  assign acc_next  = next_press && (next_inc > debounce);

  // Next state
  always_comb begin
    mode_next       = mode;
    wait_count_next = wait_count;
    unique case (mode)
      MODE_START: begin
        mode_next       = MODE_WAIT_SOURCE;
        wait_count_next = '0;
      end
      MODE_WAIT_SOURCE: begin
        wait_count_next = wait_inc;
        if (wait_inc >= TIME_BITS'(cfg.init_delay_ms)) begin
          mode_next       = MODE_WAIT_VOLUME;
          wait_count_next = '0;
        end
      end
      MODE_WAIT_VOLUME: begin
        wait_count_next = wait_inc;
        if (wait_inc >= TIME_BITS'(cfg.volume_delay_ms)) begin
          mode_next = MODE_IDLE;
        end
      end
      MODE_IDLE: begin
        mode_next = MODE_IDLE;
      end
    endcase
  end

  // Outputs: which command this tick sends
  always_comb begin
    emit            = 1'b0;
    cmd             = CMD_SELECT_SOURCE;
    p2              = NO_PARAM;
    play_flag_next  = play_flag;
    pause_flag_next = pause_flag;
    unique case (mode)
      MODE_START: begin
        emit = 1'b1;
        cmd  = CMD_SELECT_SOURCE;
        p2   = SOURCE_SD;
      end
      MODE_WAIT_SOURCE: begin
        if (wait_inc >= TIME_BITS'(cfg.init_delay_ms)) begin
          emit = 1'b1;
          cmd  = CMD_SET_VOLUME;
          p2   = 8'(cfg.volume_level);
        end
      end
      MODE_WAIT_VOLUME: begin
        emit = 1'b0;
      end
      MODE_IDLE: begin
        priority if (acc_pause) begin
          emit = 1'b1;
          if (play_flag) begin
            cmd             = CMD_PAUSE;
            play_flag_next  = 1'b0;
            pause_flag_next = 1'b1;
          end else begin
            cmd             = CMD_RESUME;
            play_flag_next  = 1'b1;
            pause_flag_next = 1'b0;
          end
        end else if (acc_prev) begin
          emit = 1'b1;
          cmd  = CMD_PREVIOUS;
        end else if (acc_next) begin
          emit = 1'b1;
          cmd  = CMD_NEXT;
        end else if (play_request) begin
          emit            = 1'b1;
          cmd             = CMD_PLAY_TRACK;
          p2              = FIRST_TRACK;
          play_flag_next  = 1'b1;
          pause_flag_next = 1'b0;
        end else begin
          emit = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_START;
      wait_count     <= '0;
      pause_since    <= '0;
      previous_since <= '0;
      next_since     <= '0;
      play_flag      <= 1'b1;
      pause_flag     <= 1'b0;
      desc_valid     <= 1'b0;
    end else begin
      desc_valid <= tick_valid && emit;
      if (tick_valid) begin
        mode           <= mode_next;
        wait_count     <= wait_count_next;
        pause_since    <= acc_pause ? '0 : pause_inc;
        previous_since <= acc_prev ? '0 : previous_inc;
        next_since     <= acc_next ? '0 : next_inc;
        play_flag      <= play_flag_next;
        pause_flag     <= pause_flag_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_valid) begin
      desc.cmd     <= cmd;
      desc.p2      <= p2;
      desc.chk     <= frame_checksum(cmd, p2);
      desc.playing <= play_flag_next;
      desc.paused  <= pause_flag_next;
    end
  end

  mode_not_idle_flags : assert property (@(posedge clk) disable iff (rst)
    (mode != MODE_IDLE) |-> (play_flag && !pause_flag))
    else $error("flags changed before idle");

  flags_exclusive : assert property (@(posedge clk) disable iff (rst)
    play_flag != pause_flag)
    else $error("playing and paused flags agree");

  start_leaves : assert property (@(posedge clk) disable iff (rst)
    (tick_valid && mode == MODE_START) |=> (desc_valid && mode == MODE_WAIT_SOURCE))
    else $error("start-up tick did not send select-source");

endmodule

`default_nettype wire

// ===== hdl/amcs_serializer.sv =====
`default_nettype none

module amcs_serializer
  import amcs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      desc_valid,
  input  wire cmd_desc_t desc,
  output logic           slot_free,
  amcs_frame_if.source   frame_out
);

  logic                pending_valid;
  cmd_desc_t           pending;
  logic                busy;
  cmd_desc_t           active;
  logic [IDX_BITS-1:0] idx;
  logic                out_take, at_last, load;

  // Free only when no command sits in the slot and none is on its way into it
  assign slot_free = !pending_valid && !desc_valid;
  assign out_take  = frame_out.valid && frame_out.ready;
  assign at_last   = (idx == IDX_BITS'(FRAME_LEN - 1));
  assign load      = pending_valid && (!busy || (out_take && at_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_valid <= 1'b0;
      busy          <= 1'b0;
      idx           <= '0;
    end else begin
      if (desc_valid) begin
        pending_valid <= 1'b1;
      end else if (load) begin
        pending_valid <= 1'b0;
      end
      if (load) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (out_take) begin
        if (at_last) begin
          busy <= 1'b0;
          idx  <= '0;
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (desc_valid) begin
      pending <= desc;
    end
    if (load) begin
      active <= pending;
    end
  end

  always_comb begin
    unique case (idx)
      IDX_BITS'(0): frame_out.frame_byte = FRAME_HEAD;
      IDX_BITS'(1): frame_out.frame_byte = VERSION_BYTE;
      IDX_BITS'(2): frame_out.frame_byte = LENGTH_BYTE;
      IDX_BITS'(3): frame_out.frame_byte = active.cmd;
      IDX_BITS'(4): frame_out.frame_byte = FEEDBACK_BYTE;
      IDX_BITS'(5): frame_out.frame_byte = PARAM1_BYTE;
      IDX_BITS'(6): frame_out.frame_byte = active.p2;
      IDX_BITS'(7): frame_out.frame_byte = active.chk[15:8];
      IDX_BITS'(8): frame_out.frame_byte = active.chk[7:0];
      default:      frame_out.frame_byte = FRAME_TAIL;
    endcase
  end

  assign frame_out.valid     = busy;
  assign frame_out.last_byte = at_last;
  assign frame_out.playing   = active.playing;
  assign frame_out.paused    = active.paused;

  idx_in_range : assert property (@(posedge clk) disable iff (rst)
    idx <= IDX_BITS'(FRAME_LEN - 1))
    else $error("byte index past end of frame");

  last_is_end : assert property (@(posedge clk) disable iff (rst)
    (busy && at_last) |-> (frame_out.frame_byte == FRAME_TAIL))
    else $error("closing byte is not the end byte");

  pending_drains : assert property (@(posedge clk) disable iff (rst)
    (pending_valid && !busy) |=> busy)
    else $error("waiting command not started");

  no_overwrite : assert property (@(posedge clk) disable iff (rst)
    (pending_valid && !load) |-> !desc_valid)
    else $error("waiting command overwritten");

endmodule

`default_nettype wire

// ===== hdl/audio_module_command_sequencer.sv =====
// Audio module command sequencer.
// tick_in carries one millisecond tick per item: three key levels and a
// play-from-start request. frame_out carries the command frames one byte per
// item, ten bytes per frame, last_byte high on the closing end byte, with the
// playing/paused flags as they stand after that command.
// Config is a plain write port (cfg_write_en, cfg_index, cfg_data); the user must see
// that it is written only while the block is idle, as the block does not enforce it.
// Path: a tick that sends a command is registered in the command register;
// it then moves into the slot and, once the serializer is idle, into the
// active frame register, whose first byte is offered on frame_out. The frame
// then streams one byte per cycle while frame_out.ready stays high.
// Throughput: a tick is taken every cycle while neither the command register
// nor the one-entry slot holds a command; after a sending tick the input holds
// until that command has left the slot for the serializer.
// Reset (rst, synchronous): registers go to volume 20, debounce 50, delays 50
// and 100; the sequencer restarts with select-source and the key counters at 0.
// When frame_out stalls, the current byte holds; one further command waits in
// the slot, after which tick_in.ready drops until the frame in flight ends.
`default_nettype none

module audio_module_command_sequencer
  import amcs_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write_en,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [CFG_BITS-1:0] cfg_data,
  amcs_tick_if.sink                tick_in,
  amcs_frame_if.source             frame_out
);

  cfg_t      cfg;
  logic      slot_free;
  logic      tick_take;
  logic      desc_valid;
  cmd_desc_t desc;

  // Register file: hold each setting until reset or a write through the config port
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.volume_level    <= VOLUME_RST;
      cfg.debounce_ms     <= DEBOUNCE_RST;
      cfg.init_delay_ms   <= INIT_DELAY_RST;
      cfg.volume_delay_ms <= VOL_DELAY_RST;
    end else if (cfg_write_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_VOLUME:     cfg.volume_level    <= cfg_data[4:0];
        REG_DEBOUNCE:   cfg.debounce_ms     <= cfg_data;
        REG_INIT_DELAY: cfg.init_delay_ms   <= cfg_data;
        REG_VOL_DELAY:  cfg.volume_delay_ms <= cfg_data;
      endcase
    end
  end

  // Take a tick whenever the command slot can absorb what it may send
  assign tick_in.ready = slot_free;
  assign tick_take     = tick_in.valid && slot_free;

  // Tick processing: counters, debounce, start-up sequence, key priority
  amcs_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .tick_valid   (tick_take),
    .pause_press  (tick_in.pause_press),
    .prev_press   (tick_in.prev_press),
    .next_press   (tick_in.next_press),
    .play_request (tick_in.play_request),
    .desc_valid   (desc_valid),
    .desc         (desc)
  );

  // Framing: hold one command in the slot, stream the active one byte by byte
  amcs_serializer u_ser (
    .clk        (clk),
    .rst        (rst),
    .desc_valid (desc_valid),
    .desc       (desc),
    .slot_free  (slot_free),
    .frame_out  (frame_out)
  );

  tick_blocked_when_full : assert property (@(posedge clk) disable iff (rst)
    !slot_free |-> !tick_take)
    else $error("tick taken with command slot full");

  cmd_follows_tick : assert property (@(posedge clk) disable iff (rst)
    desc_valid |-> $past(tick_take))
    else $error("command without a tick");

  frame_flags_exclusive : assert property (@(posedge clk) disable iff (rst)
    frame_out.valid |-> (frame_out.playing != frame_out.paused))
    else $error("frame flags agree");

endmodule

`default_nettype wire
